// ===== rtl/core/kpsc_pkg.sv =====
// Shared types, constants and the key lookup for the keypad scanner.
// Used by every module of the keypad scan / PIN entry core.
package kpsc_pkg;

  localparam int unsigned PIN_LENGTH_DEF   = 4;
  localparam logic [15:0] SETTLE_RESET     = 16'd3000;
  localparam int unsigned CfgAddrW         = 3;

  // register index taken from the byte address
  localparam logic        REG_SETTLE_TICKS = 1'b0;

  localparam logic [3:0]  KEY_STAR         = 4'd10;
  localparam logic [3:0]  KEY_POUND        = 4'd11;

  typedef enum logic [1:0] {
    PH_SETTLE = 2'b01,
    PH_HOLD   = 2'b10
  } phase_e;

  typedef struct packed {
    logic [3:0]  row_drive;
    logic        key_valid;
    logic [3:0]  key_code;
    logic        pin_valid;
    logic [15:0] pin_digits;
    logic        short_entry;
  } result_t;

  function automatic logic [3:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] code;
    code = 4'd0;
    case ({row, col})
      4'b00_00: code = 4'd1;
      4'b00_01: code = 4'd2;
      4'b00_10: code = 4'd3;
      4'b01_00: code = 4'd4;
      4'b01_01: code = 4'd5;
      4'b01_10: code = 4'd6;
      4'b10_00: code = 4'd7;
      4'b10_01: code = 4'd8;
      4'b10_10: code = 4'd9;
      4'b11_00: code = KEY_STAR;
      4'b11_01: code = 4'd0;
      4'b11_10: code = KEY_POUND;
      default:  code = 4'd0;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/core/keypad_scan_pin_entry_core.sv =====
// A column sample is captured in the input register (cols_q), and its result in the
// result register (res_q). Throughput: one transaction per cycle while the output is not stalled.
// The settle counter in kpsc_scan paces the row scan, one count per transaction.
// Reset (rst_ni low, asynchronous) returns the scan to row 1, settling, with an
// empty PIN and settle interval 3000; both pipeline registers empty.
// Top level: kpsc_cfg register port and kpsc_scan, depends on kpsc_pkg.
module keypad_scan_pin_entry_core import kpsc_pkg::*; #(
  parameter int unsigned PIN_LENGTH = PIN_LENGTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          column_levels_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [3:0]          row_drive_o,
  output logic                key_valid_o,
  output logic [3:0]          key_code_o,
  output logic                pin_valid_o,
  output logic [15:0]         pin_digits_o,
  output logic                short_entry_o
);

  logic [15:0] settle_ticks;
  logic        in_valid_q;
  logic [2:0]  cols_q;
  logic        out_valid_q;
  result_t     res_q;
  result_t     res;
  logic        advance;

  kpsc_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .settle_ticks_o (settle_ticks)
  );

  kpsc_scan #(
    .PIN_LENGTH (PIN_LENGTH)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .settle_ticks_i (settle_ticks),
    .cols_i         (cols_q),
    .res_o          (res)
  );

  // held sample moves into the result register when that is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      cols_q <= column_levels_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign row_drive_o   = res_q.row_drive;
  assign key_valid_o   = res_q.key_valid;
  assign key_code_o    = res_q.key_code;
  assign pin_valid_o   = res_q.pin_valid;
  assign pin_digits_o  = res_q.pin_digits;
  assign short_entry_o = res_q.short_entry;

endmodule

// ===== rtl/core/kpsc_cfg.sv =====
// APB-style register port holding the settle interval.
// Depends on kpsc_pkg for the reset value and register index.
module kpsc_cfg import kpsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output logic [15:0]         settle_ticks_o
);

  logic [15:0] settle_q;
  logic [15:0] settle_d;
  logic        wr_en;
  logic        sel_settle;

  assign sel_settle = (paddr[2] == REG_SETTLE_TICKS);
  assign wr_en      = psel && penable && pwrite && sel_settle;
  assign pready     = 1'b1;

  always_comb begin
    settle_d = settle_q;
    if (wr_en) begin
      settle_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SETTLE_RESET;
    end else begin
      settle_q <= settle_d;
    end
  end

  // paddr[1:0] is the byte lane and is not decoded
  assign prdata         = sel_settle ? {16'd0, settle_q} : 32'd0;
  assign settle_ticks_o = settle_q;

endmodule

// ===== rtl/core/kpsc_scan.sv =====
// Scan state, key decode and PIN store; one step per transaction moved on.
// Depends on kpsc_pkg for the result struct, phase encoding and key lookup.
module kpsc_scan import kpsc_pkg::*; #(
  parameter int unsigned PIN_LENGTH = PIN_LENGTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [15:0] settle_ticks_i,
  input  logic [2:0]  cols_i,
  output result_t     res_o
);

  localparam int unsigned CntW = $clog2(PIN_LENGTH + 1);

  logic [1:0]      row_q, row_d;
  logic [15:0]     settle_cnt_q, settle_cnt_d;
  phase_e          phase_q, phase_d;
  logic [1:0]      held_q, held_d;
  logic [3:0]      pin_q [PIN_LENGTH];
  logic [3:0]      pin_d [PIN_LENGTH];
  logic [CntW-1:0] dcnt_q, dcnt_d;

  logic [16:0]     cnt_inc;
  logic [16:0]     limit;
  logic            any_low;
  logic [1:0]      col_sel;
  logic [3:0]      code;
  logic [15:0]     pin_packed;
  logic [3:0]      cols_ext;
  logic            released;
  logic            pin_full;

  // newest digits in the low nibbles; absent nibbles stay zero
  for (genvar k = 0; k < 4; k++) begin : g_pack
    if (k < PIN_LENGTH) begin : g_used
      assign pin_packed[4*k +: 4] = pin_q[PIN_LENGTH-1-k];
    end else begin : g_zero
      assign pin_packed[4*k +: 4] = 4'd0;
    end
  end

  assign cnt_inc  = {1'b0, settle_cnt_q} + 17'd1;
  assign limit    = (settle_ticks_i == 16'd0) ? 17'd1 : {1'b0, settle_ticks_i};
  assign any_low  = (cols_i != 3'b111);
  assign col_sel  = !cols_i[0] ? 2'd0 : (!cols_i[1] ? 2'd1 : 2'd2);
  assign code     = key_lookup(row_q, col_sel);
  assign cols_ext = {1'b1, cols_i};
  assign released = cols_ext[held_q];
  assign pin_full = (dcnt_q >= CntW'(PIN_LENGTH));

  always_comb begin
    res_o           = '0;
    res_o.row_drive = 4'b0001 << row_q;
    row_d           = row_q;
    settle_cnt_d    = settle_cnt_q;
    phase_d         = phase_q;
    held_d          = held_q;
    pin_d           = pin_q;
    dcnt_d          = dcnt_q;

    if (cnt_inc < limit) begin
      settle_cnt_d = cnt_inc[15:0];
    end else begin
      settle_cnt_d = 16'd0;
      case (phase_q)
        PH_SETTLE: begin
          if (any_low) begin
            res_o.key_valid = 1'b1;
            res_o.key_code  = code;
            phase_d         = PH_HOLD;
            held_d          = col_sel;
            if (code == KEY_POUND) begin
              if (pin_full) begin
                res_o.pin_valid  = 1'b1;
                res_o.pin_digits = pin_packed;
                for (int i = 0; i < PIN_LENGTH; i++) begin
                  pin_d[i] = 4'd0;
                end
                dcnt_d = '0;
              end else begin
                res_o.short_entry = 1'b1;
              end
            end else if (code != KEY_STAR) begin
              for (int i = 0; i + 1 < PIN_LENGTH; i++) begin
                pin_d[i] = pin_q[i+1];
              end
              pin_d[PIN_LENGTH-1] = code;
              if (!pin_full) begin
                dcnt_d = dcnt_q + CntW'(1);
              end
            end
          end else begin
            row_d = row_q + 2'd1;
          end
        end
        PH_HOLD: begin
          if (released) begin
            phase_d = PH_SETTLE;
            row_d   = row_q + 2'd1;
          end
        end
        default: begin
          phase_d = PH_SETTLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q        <= 2'd0;
      settle_cnt_q <= 16'd0;
      phase_q      <= PH_SETTLE;
      held_q       <= 2'd0;
      dcnt_q       <= '0;
      for (int i = 0; i < PIN_LENGTH; i++) begin
        pin_q[i] <= 4'd0;
      end
    end else if (step_i) begin
      row_q        <= row_d;
      settle_cnt_q <= settle_cnt_d;
      phase_q      <= phase_d;
      held_q       <= held_d;
      dcnt_q       <= dcnt_d;
      pin_q        <= pin_d;
    end
  end

  a_row_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(res_o.row_drive))
    else $error("row drive not one-hot");

  a_press_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.key_valid |=> phase_q == PH_HOLD && held_q != 2'd3)
    else $error("reported press did not latch the held column");

  a_pin_on_pound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.pin_valid || res_o.short_entry |->
      res_o.key_valid && res_o.key_code == KEY_POUND
      && !(res_o.pin_valid && res_o.short_entry))
    else $error("PIN outcome without a single pound press");

  a_pin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.pin_valid |=> dcnt_q == '0)
    else $error("digit count not cleared after PIN output");

endmodule
